### rtl/core/adc_oversample_vref_scaler_defines.svh
`ifndef ADC_OVERSAMPLE_VREF_SCALER_DEFINES_SVH
`define ADC_OVERSAMPLE_VREF_SCALER_DEFINES_SVH

// Assertion helpers. The including module must provide clk and rst.

// The consequence must hold in the same cycle as the antecedent.
`define AVOS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define AVOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/avos_pkg.sv
package avos_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int OUT_W       = 24;
  localparam int CHANNELS    = 9;
  localparam int MEAS_CH     = CHANNELS - 1;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 9;
  localparam int CAL_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int CH_IDX_W    = $clog2(CHANNELS);
  localparam int CH_CNT_W    = $clog2(CHANNELS + 1);
  localparam int MEAS_IDX_W  = $clog2(MEAS_CH);
  localparam int MAX_WINDOW  = 256;
  localparam int UV_PER_MV   = 1000;
  // cal_supply_mv * ref_cal_code * 1000 fits in 34 bits.
  localparam int NUM_W       = 34;
  localparam int HALF_W      = NUM_W / 2;
  localparam int PROD_W      = SUM_W + NUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_CAL_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SUPPLY_MV = 2'd2;

  localparam logic [CNT_W-1:0] NUM_SAMPLES_RST   = 9'd16;
  localparam logic [CAL_W-1:0] REF_CAL_CODE_RST  = 12'd1655;
  localparam logic [CAL_W-1:0] CAL_SUPPLY_MV_RST = 12'd3000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [SAMPLE_W-1:0] sample_ch4;
    logic [SAMPLE_W-1:0] sample_ch5;
    logic [SAMPLE_W-1:0] sample_ch6;
    logic [SAMPLE_W-1:0] sample_ch7;
    logic [SAMPLE_W-1:0] sample_ch8;
    logic [SAMPLE_W-1:0] sample_ref;
    logic                scan_ok;
  } scan_t;

  typedef struct packed {
    logic [OUT_W-1:0] volt_ch1_uv;
    logic [OUT_W-1:0] volt_ch2_uv;
    logic [OUT_W-1:0] volt_ch3_uv;
    logic [OUT_W-1:0] volt_ch4_uv;
    logic [OUT_W-1:0] volt_ch5_uv;
    logic [OUT_W-1:0] volt_ch6_uv;
    logic [OUT_W-1:0] volt_ch7_uv;
    logic [OUT_W-1:0] volt_ch8_uv;
    logic [OUT_W-1:0] supply_uv;
    logic             ref_zero_error;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_AVG_RD,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_REF_MUL,
    ST_REF_SCALE,
    ST_SUP_GO,
    ST_SUP_WAIT,
    ST_VOLT_RD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_VOLT_GO,
    ST_VOLT_WAIT,
    ST_DONE
  } state_t;

endpackage

### rtl/core/avos_ram.sv
module avos_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/avos_div.sv
module avos_div #(
  parameter int DVD_W = 54,
  parameter int DVS_W = 36
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [DVS_W-1:0]           divisor,
  output logic [avos_pkg::OUT_W-1:0] quotient,
  output avos_pkg::div_stat_t        stat
);

  import avos_pkg::*;

  localparam int CW     = (DVD_W > DVS_W + OUT_W) ? DVD_W : DVS_W + OUT_W;
  localparam int STEP_W = $clog2(OUT_W);

  logic [CW-1:0]     rem;
  logic [CW-1:0]     dsh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              sat;
  logic              ge;

  // The quotient overflows the output exactly when dividend >= divisor * 2^OUT_W,
  // which only needs the upper part of the dividend.
  assign sat = CW'(dividend[DVD_W-1:OUT_W]) >= CW'(divisor);
  assign ge  = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= ~sat;
        done <= sat;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= CW'(dividend);
      dsh      <= CW'(divisor) << (OUT_W - 1);
      quotient <= sat ? '1 : '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[OUT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/core/adc_oversample_vref_scaler.sv
// Flow: a warm-up scan, or a skipped scan that closes no window, leaves the FSM idle;
// a summed scan makes 9 channel read-modify-writes on the sum memory. Closing a window
// adds up to 18 divisions on the shared divider, plus reads of the sum memory.
// A new scan is stalled until the last one is through; the result waits in an output
// register while the next scans are taken, and a later close waits until it is free.
// Reset: synchronous; sums read as zero, counters cleared, registers to defaults.
`include "adc_oversample_vref_scaler_defines.svh"

module adc_oversample_vref_scaler #(
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scan_valid,
  output logic                                scan_stall,
  input  avos_pkg::scan_t                     scan,
  output logic                                result_valid,
  input  logic                                result_stall,
  output avos_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [avos_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [avos_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import avos_pkg::*;

  localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
  localparam int DEN_W = SUM_W + FS_W;
  localparam int PPL_W = SUM_W + HALF_W;
  localparam int HI_W  = NUM_W - HALF_W;
  localparam int PPH_W = SUM_W + HI_W;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]    num_samples;
  logic [CAL_W-1:0]    ref_cal_code;
  logic [CAL_W-1:0]    cal_supply_mv;
  logic [CNT_W-1:0]    n_eff;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_inc;
  logic                win_hit;
  logic                warm_done;
  logic                close_q;
  logic                scan_xfer;
  logic                out_free;

  logic [CH_CNT_W-1:0] idx;
  logic [CH_IDX_W-1:0] wb_idx;
  logic                wb_valid;
  logic [CHANNELS-1:0] valid_bits;
  logic                rd_ok;

  logic                ram_we;
  logic [CH_IDX_W-1:0] ram_waddr;
  logic [SUM_W-1:0]    ram_wdata;
  logic [CH_IDX_W-1:0] ram_raddr;
  logic [SUM_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]    rdata_eff;
  logic [SUM_W:0]      acc_raw;
  logic [SUM_W-1:0]    acc_sum;

  scan_t               scan_q;
  logic [SAMPLE_W-1:0] samp [CHANNELS];

  logic                div_start;
  logic [PROD_W-1:0]   div_dvd;
  logic [DEN_W-1:0]    div_dvs;
  logic [OUT_W-1:0]    div_q;
  div_stat_t           div_stat;

  logic [SUM_W-1:0]    avg_ref;
  logic [SUM_W-1:0]    avg_q;
  logic [2*CAL_W-1:0]  cal_prod;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [PPL_W-1:0]    pp_lo;
  logic [PPH_W-1:0]    pp_hi;
  logic [PROD_W-1:0]   prod_sum;

  logic [OUT_W-1:0]    volt_work [MEAS_CH];
  logic [OUT_W-1:0]    supply_work;
  logic                err_work;

  assign scan_stall = (state != ST_IDLE);
  assign scan_xfer  = scan_valid & ~scan_stall;
  assign out_free   = ~result_valid | ~result_stall;

  always_comb begin
    if (num_samples == '0) begin
      n_eff = CNT_W'(1);
    end else if (num_samples > CNT_W'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = num_samples;
    end
  end

  assign cnt_inc = cnt + 1'b1;
  assign win_hit = cnt_inc >= n_eff;

  assign samp[0] = scan_q.sample_ch1;
  assign samp[1] = scan_q.sample_ch2;
  assign samp[2] = scan_q.sample_ch3;
  assign samp[3] = scan_q.sample_ch4;
  assign samp[4] = scan_q.sample_ch5;
  assign samp[5] = scan_q.sample_ch6;
  assign samp[6] = scan_q.sample_ch7;
  assign samp[7] = scan_q.sample_ch8;
  assign samp[8] = scan_q.sample_ref;

  // Entries never written since the last window close read as zero.
  assign rdata_eff = rd_ok ? ram_rdata : '0;
  assign acc_raw   = (SUM_W+1)'(rdata_eff) + (SUM_W+1)'(samp[wb_idx]);
  assign acc_sum   = acc_raw[SUM_W] ? '1 : acc_raw[SUM_W-1:0];
  assign prod_sum  = PROD_W'(pp_lo) + (PROD_W'(pp_hi) << HALF_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    case (state)
      ST_IDLE: begin
        if (scan_xfer && warm_done) begin
          if (scan.scan_ok) begin
            state_next = ST_ACC;
          end else if (win_hit) begin
            state_next = ST_AVG_RD;
          end
        end
      end
      ST_ACC: begin
        // Read of entry k overlaps the write-back of entry k-1, so the two
        // accesses never meet on one entry.
        if (idx != CH_CNT_W'(CHANNELS)) begin
          ram_raddr = idx[CH_IDX_W-1:0];
        end
        if (wb_valid) begin
          ram_we    = 1'b1;
          ram_waddr = wb_idx;
          ram_wdata = acc_sum;
          if (idx == CH_CNT_W'(CHANNELS)) begin
            state_next = close_q ? ST_AVG_RD : ST_IDLE;
          end
        end
      end
      ST_AVG_RD: begin
        ram_raddr  = idx[CH_IDX_W-1:0];
        state_next = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        div_start  = 1'b1;
        state_next = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_stat.done) begin
          ram_we    = 1'b1;
          ram_waddr = idx[CH_IDX_W-1:0];
          ram_wdata = div_q[SUM_W-1:0];
          if (idx == CH_CNT_W'(CHANNELS - 1)) begin
            state_next = ST_REF_MUL;
          end else begin
            state_next = ST_AVG_RD;
          end
        end
      end
      ST_REF_MUL: begin
        state_next = ST_REF_SCALE;
      end
      ST_REF_SCALE: begin
        state_next = (avg_ref == '0) ? ST_DONE : ST_SUP_GO;
      end
      ST_SUP_GO: begin
        div_start  = 1'b1;
        state_next = ST_SUP_WAIT;
      end
      ST_SUP_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_VOLT_RD;
        end
      end
      ST_VOLT_RD: begin
        ram_raddr  = idx[CH_IDX_W-1:0];
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_next = ST_VOLT_GO;
      end
      ST_VOLT_GO: begin
        div_start  = 1'b1;
        state_next = ST_VOLT_WAIT;
      end
      ST_VOLT_WAIT: begin
        if (div_stat.done) begin
          if (idx == CH_CNT_W'(MEAS_CH - 1)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_VOLT_RD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_SUP_GO: begin
        div_dvd = PROD_W'(num);
        div_dvs = DEN_W'(avg_ref);
      end
      ST_VOLT_GO: begin
        div_dvd = prod_sum;
        div_dvs = den;
      end
      default: begin
        div_dvd = PROD_W'(rdata_eff);
        div_dvs = DEN_W'(n_eff);
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples   <= NUM_SAMPLES_RST;
      ref_cal_code  <= REF_CAL_CODE_RST;
      cal_supply_mv <= CAL_SUPPLY_MV_RST;
      cnt           <= '0;
      warm_done     <= 1'b0;
      close_q       <= 1'b0;
      idx           <= '0;
      wb_valid      <= 1'b0;
      valid_bits    <= '0;
      rd_ok         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NUM_SAMPLES:   num_samples   <= cfg_data[CNT_W-1:0];
          CFG_REF_CAL_CODE:  ref_cal_code  <= cfg_data[CAL_W-1:0];
          CFG_CAL_SUPPLY_MV: cal_supply_mv <= cfg_data[CAL_W-1:0];
          default: ;
        endcase
      end

      rd_ok <= valid_bits[ram_raddr];
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end

      if (scan_xfer) begin
        idx      <= '0;
        wb_valid <= 1'b0;
        if (!warm_done) begin
          // Warm-up scans only advance the counter and, on the last one, end the warm-up.
          warm_done <= win_hit;
          cnt       <= win_hit ? '0 : cnt_inc;
        end else begin
          close_q <= win_hit;
          cnt     <= win_hit ? '0 : cnt_inc;
        end
      end

      case (state)
        ST_ACC: begin
          wb_valid <= (idx != CH_CNT_W'(CHANNELS));
          // The last write-back leaves the index at zero for the averaging pass.
          idx <= (idx != CH_CNT_W'(CHANNELS)) ? idx + 1'b1 : '0;
        end
        ST_AVG_WAIT: begin
          if (div_stat.done) begin
            idx <= (idx == CH_CNT_W'(CHANNELS - 1)) ? '0 : idx + 1'b1;
          end
        end
        ST_VOLT_WAIT: begin
          if (div_stat.done) begin
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase

      if (state == ST_DONE && out_free) begin
        // Clearing the valid bits empties all sums for the next window.
        valid_bits   <= '0;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (scan_xfer) begin
      scan_q <= scan;
    end
    if (state == ST_ACC) begin
      wb_idx <= idx[CH_IDX_W-1:0];
    end
    case (state)
      ST_AVG_WAIT: begin
        if (div_stat.done && idx == CH_CNT_W'(CHANNELS - 1)) begin
          avg_ref <= div_q[SUM_W-1:0];
        end
      end
      ST_REF_MUL: begin
        cal_prod <= (2*CAL_W)'(cal_supply_mv) * (2*CAL_W)'(ref_cal_code);
        den      <= DEN_W'(avg_ref) * DEN_W'(ADC_FULL_SCALE);
      end
      ST_REF_SCALE: begin
        num <= NUM_W'(cal_prod) * NUM_W'(UV_PER_MV);
        if (avg_ref == '0) begin
          err_work    <= 1'b1;
          supply_work <= '0;
          for (int i = 0; i < MEAS_CH; i++) begin
            volt_work[i] <= '0;
          end
        end else begin
          err_work <= 1'b0;
        end
      end
      ST_SUP_WAIT: begin
        if (div_stat.done) begin
          supply_work <= div_q;
        end
      end
      ST_MUL_LO: begin
        avg_q <= rdata_eff;
        pp_lo <= PPL_W'(rdata_eff) * PPL_W'(num[HALF_W-1:0]);
      end
      ST_MUL_HI: begin
        pp_hi <= PPH_W'(avg_q) * PPH_W'(num[NUM_W-1:HALF_W]);
      end
      ST_VOLT_WAIT: begin
        if (div_stat.done) begin
          volt_work[idx[MEAS_IDX_W-1:0]] <= div_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          result.volt_ch1_uv    <= volt_work[0];
          result.volt_ch2_uv    <= volt_work[1];
          result.volt_ch3_uv    <= volt_work[2];
          result.volt_ch4_uv    <= volt_work[3];
          result.volt_ch5_uv    <= volt_work[4];
          result.volt_ch6_uv    <= volt_work[5];
          result.volt_ch7_uv    <= volt_work[6];
          result.volt_ch8_uv    <= volt_work[7];
          result.supply_uv      <= supply_work;
          result.ref_zero_error <= err_work;
        end
      end
      default: ;
    endcase
  end

  avos_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  avos_div #(
    .DVD_W (PROD_W),
    .DVS_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  `AVOS_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy,
                   "divider started while busy")
  `AVOS_ASSERT_NOW(a_acc_no_overlap, (state == ST_ACC) && ram_we, ram_waddr != ram_raddr,
                   "sum write-back collides with sum read")
  `AVOS_ASSERT_NOW(a_result_after_warmup, $rose(result_valid), warm_done,
                   "result produced during warm-up")
  `AVOS_ASSERT_NEXT(a_sums_cleared, (state == ST_DONE) && out_free, valid_bits == '0,
                    "sums not cleared at window close")

endmodule

### dv/adc_oversample_vref_scaler_tb.sv
module adc_oversample_vref_scaler_tb;
  import avos_pkg::*;

  localparam int FULL_SCALE = 4095;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DIRECTED_ITEMS = 43;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned UV_MAX = 64'd16777215;
  localparam int unsigned SUM_CEIL = 1048575;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic scan_valid = 1'b0;
  logic scan_stall;
  scan_t scan = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scan_t pending_scans[$];
  result_t expected_results[$];
  int scans_queued = 0;
  int scans_accepted = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 37;
  int receiver_stall_pct = 79;

  // Register copies and accumulator state kept by the predictor.
  logic [CNT_W-1:0] cfg_window = NUM_SAMPLES_RST;
  logic [CAL_W-1:0] cfg_vref_cal = REF_CAL_CODE_RST;
  logic [CAL_W-1:0] cfg_supply_mv = CAL_SUPPLY_MV_RST;
  logic [SUM_W-1:0] chan_sums [CHANNELS] = '{default: '0};
  int unsigned window_count = 0;
  bit warm = 1'b0;

  adc_oversample_vref_scaler u_top (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .scan         (scan),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned window_of(input logic [CNT_W-1:0] win);
    if (win == 0) return 1;
    if (win > MAX_WINDOW) return MAX_WINDOW;
    return 32'(win);
  endfunction

  function automatic logic [OUT_W-1:0] sat_uv(input longint unsigned v);
    return (v > UV_MAX) ? UV_MAX[OUT_W-1:0] : v[OUT_W-1:0];
  endfunction

  // Sums one good scan after warm-up and, when a scan closes a window after warm-up, predicts the converted result.
  task automatic accumulate_scan(input scan_t s);
    logic [SAMPLE_W-1:0] raw [CHANNELS];
    logic [OUT_W-1:0] volts [CHANNELS];
    longint unsigned n, num, avg_ref, den;
    int unsigned total;
    result_t r;
    raw = '{s.sample_ch1, s.sample_ch2, s.sample_ch3, s.sample_ch4, s.sample_ch5,
            s.sample_ch6, s.sample_ch7, s.sample_ch8, s.sample_ref};
    n = 64'(window_of(cfg_window));
    if (warm && s.scan_ok) begin
      for (int i = 0; i < CHANNELS; i++) begin
        total = chan_sums[i] + raw[i];
        chan_sums[i] = SUM_W'((total > SUM_CEIL) ? SUM_CEIL : total);
      end
    end
    window_count = window_count + 1;
    if (window_count < n) return;
    window_count = 0;
    if (!warm) begin
      warm = 1'b1;
      return;
    end
    num = 64'(cfg_supply_mv) * cfg_vref_cal * UV_PER_MV;
    avg_ref = chan_sums[CHANNELS-1] / n;
    r = '0;
    if (avg_ref == 0) begin
      r.ref_zero_error = 1'b1;
    end else begin
      den = avg_ref * FULL_SCALE;
      for (int i = 0; i < CHANNELS - 1; i++) begin
        volts[i] = sat_uv((chan_sums[i] / n) * num / den);
      end
      volts[CHANNELS-1] = sat_uv(num / avg_ref);
      r.volt_ch1_uv = volts[0];
      r.volt_ch2_uv = volts[1];
      r.volt_ch3_uv = volts[2];
      r.volt_ch4_uv = volts[3];
      r.volt_ch5_uv = volts[4];
      r.volt_ch6_uv = volts[5];
      r.volt_ch7_uv = volts[6];
      r.volt_ch8_uv = volts[7];
      r.supply_uv = volts[8];
    end
    expected_results.push_back(r);
    foreach (chan_sums[i]) chan_sums[i] = '0;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CAL_W-1:0] rand_cal();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 12'd3600;
      default: return CAL_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic scan_t random_scan();
    scan_t s;
    s.sample_ch1 = rand_sample();
    s.sample_ch2 = rand_sample();
    s.sample_ch3 = rand_sample();
    s.sample_ch4 = rand_sample();
    s.sample_ch5 = rand_sample();
    s.sample_ch6 = rand_sample();
    s.sample_ch7 = rand_sample();
    s.sample_ch8 = rand_sample();
    // Small reference readings push the supply and channel voltages into saturation.
    case ($urandom_range(0, 7))
      0: s.sample_ref = '0;
      1: s.sample_ref = SAMPLE_W'($urandom_range(1, 400));
      default: s.sample_ref = SAMPLE_W'($urandom_range(0, 4095));
    endcase
    s.scan_ok = ($urandom_range(0, 99) < 85);
    return s;
  endfunction

  function automatic scan_t uniform_scan(input logic [SAMPLE_W-1:0] ch,
                                         input logic [SAMPLE_W-1:0] refv, input logic ok);
    return '{ch, ch, ch, ch, ch, ch, ch, ch, refv, ok};
  endfunction

  task automatic queue_scan(input scan_t s);
    pending_scans.push_back(s);
    scans_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_NUM_SAMPLES: cfg_window = data[CNT_W-1:0];
      CFG_REF_CAL_CODE: cfg_vref_cal = data;
      CFG_CAL_SUPPLY_MV: cfg_supply_mv = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued scan is taken and every predicted result has arrived,
  // then gives a scan that closed no window time to finish.
  task automatic drain();
    while (scans_accepted < scans_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] expv,
                             input logic [OUT_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else begin
      if (scan_valid && !scan_stall) begin
        accumulate_scan(scan);
        scans_accepted++;
      end
      if (!scan_valid || !scan_stall) begin
        if (pending_scans.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          scan <= pending_scans.pop_front();
          scan_valid <= 1'b1;
        end else begin
          scan_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no closed window pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("volt_ch1_uv", want.volt_ch1_uv, result.volt_ch1_uv);
        check_field("volt_ch2_uv", want.volt_ch2_uv, result.volt_ch2_uv);
        check_field("volt_ch3_uv", want.volt_ch3_uv, result.volt_ch3_uv);
        check_field("volt_ch4_uv", want.volt_ch4_uv, result.volt_ch4_uv);
        check_field("volt_ch5_uv", want.volt_ch5_uv, result.volt_ch5_uv);
        check_field("volt_ch6_uv", want.volt_ch6_uv, result.volt_ch6_uv);
        check_field("volt_ch7_uv", want.volt_ch7_uv, result.volt_ch7_uv);
        check_field("volt_ch8_uv", want.volt_ch8_uv, result.volt_ch8_uv);
        check_field("supply_uv", want.supply_uv, result.supply_uv);
        check_field("ref_zero_error", OUT_W'(want.ref_zero_error),
                    OUT_W'(result.ref_zero_error));
      end
    end
    result_stall <= !rst && ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (scan_valid && !scan_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CNT_W-1:0] win;
    int unsigned n_eff, len;
    int phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Warm-up and the first window run at the reset register values.
    repeat (16) queue_scan(random_scan());
    queue_scan(uniform_scan(12'hFFF, 12'hFFF, 1'b1));
    queue_scan(uniform_scan(12'h000, 12'h000, 1'b1));
    queue_scan(uniform_scan(12'hFFF, 12'hFFF, 1'b0));
    repeat (13) queue_scan(random_scan());
    drain();

    // Single-scan windows at full calibration: saturation and a zero reference.
    write_reg(CFG_NUM_SAMPLES, 12'd1);
    write_reg(CFG_REF_CAL_CODE, 12'hFFF);
    write_reg(CFG_CAL_SUPPLY_MV, 12'hFFF);
    queue_scan(uniform_scan(12'hFFF, 12'h001, 1'b1));
    queue_scan(uniform_scan(12'hFFF, 12'h000, 1'b1));
    queue_scan(uniform_scan(12'hFFF, 12'hFFF, 1'b0));
    queue_scan(uniform_scan(12'hFFF, 12'hFFF, 1'b1));
    queue_scan(uniform_scan(12'h001, 12'hFFF, 1'b1));
    drain();

    // A zero window length acts as one; the unused index must change nothing.
    write_reg(CFG_NUM_SAMPLES, 12'd0);
    write_reg(CFG_UNUSED, 12'hFFF);
    write_reg(CFG_REF_CAL_CODE, 12'd0);
    queue_scan(uniform_scan(12'h5A5, 12'hA5A, 1'b1));
    queue_scan(uniform_scan(12'hA5A, 12'h5A5, 1'b1));
    drain();

    // Lowering the window length below the count closes the window on the next scan.
    write_reg(CFG_NUM_SAMPLES, 12'd4);
    write_reg(CFG_REF_CAL_CODE, REF_CAL_CODE_RST);
    write_reg(CFG_CAL_SUPPLY_MV, CAL_SUPPLY_MV_RST);
    repeat (3) queue_scan(random_scan());
    drain();
    write_reg(CFG_NUM_SAMPLES, 12'd2);
    queue_scan(random_scan());
    drain();

    phase = 0;
    while (scans_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (scans_queued < DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
        sender_idle_pct = 37;
        receiver_stall_pct = 79;
      end else if (scans_queued < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct = 79;
        receiver_stall_pct = 37;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      if (phase == 0) begin
        win = 9'd511;
      end else begin
        case ($urandom_range(0, 99))
          0: win = 9'd0;
          1: win = 9'd256;
          2: win = CNT_W'($urandom_range(257, 511));
          3, 4: win = 9'd1;
          default: win = CNT_W'($urandom_range(2, 12));
        endcase
      end
      write_reg(CFG_NUM_SAMPLES, {3'($urandom_range(0, 7)), win});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
      end
      write_reg(CFG_REF_CAL_CODE, rand_cal());
      write_reg(CFG_CAL_SUPPLY_MV, rand_cal());
      n_eff = window_of(win);
      if (n_eff > 16) len = n_eff + $urandom_range(0, 3);
      else len = n_eff * $urandom_range(1, 4) + $urandom_range(0, 3);
      repeat (len) queue_scan(random_scan());
      drain();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
